@@ rtl/timestamped_block_framer_defines.svh @@
// assertion macros used by the framer rtl
`ifndef TIMESTAMPED_BLOCK_FRAMER_DEFINES_SVH
`define TIMESTAMPED_BLOCK_FRAMER_DEFINES_SVH

// same-cycle implication
`define TBF_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tbf check failed");

// next-cycle implication
`define TBF_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tbf check failed");

`endif

@@ rtl/tbf_pkg.sv @@
package tbf_pkg;

	localparam int MAX_BLOCK_BYTES_DEF = 128;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_LENGTH = 2'd1,
		CMD_STAMP  = 2'd2,
		CMD_FLUSH  = 2'd3
	} cmd_t;

	localparam logic [21:0] LEN_ONE_MAX = 22'h7F;
	localparam logic [21:0] LEN_TWO_MAX = 22'h3FFF;

	typedef logic [1:0] lane_t;

	typedef struct packed {
		logic  wr_en;
		logic  rd_en;
		lane_t lane;
	} buf_ctl_t;

endpackage

@@ rtl/tbf_buffer.sv @@
module tbf_buffer
	import tbf_pkg::*;
#(
	parameter int MaxBlockBytes = MAX_BLOCK_BYTES_DEF,
	localparam int Words = (MaxBlockBytes + 3) / 4,
	localparam int AddrW = (Words > 1) ? $clog2(Words) : 1
) (
	input  logic                       clk,
	input  buf_ctl_t                   ctl,
	input  logic [AddrW-1:0]           wr_addr,
	input  logic [7:0]                 wr_data,
	input  logic [AddrW-1:0]           rd_addr,
	output logic [3:0][7:0]            rd_data
);

	logic [3:0][7:0] mem_q [Words];

	// lane 0 is the first byte of a word, held in the top bits
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr][~ctl.lane] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/timestamped_block_framer.sv @@
// a flush enters ST_HDR, which then registers the first frame word into word_q
// throughput: one frame word per cycle while frame_stall is low
// a write or flush holds off input until its bytes are stored or its frame words are sent
// arst_n clears the byte count, the timestamp, the sequencer and the output valid
// buffer contents are not cleared; bytes past the count are masked to zero
`include "timestamped_block_framer_defines.svh"

module timestamped_block_framer
	import tbf_pkg::*;
#(
	parameter int MaxBlockBytes = MAX_BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] value,
	input  logic [2:0]  nbytes,
	input  logic        stamp_flush,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [31:0] word,
	output logic        last
);

	localparam int Words  = (MaxBlockBytes + 3) / 4;
	localparam int AddrW  = (Words > 1) ? $clog2(Words) : 1;
	localparam int CountW = $clog2(MaxBlockBytes + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_BYTES = 5'b00010,
		ST_HDR   = 5'b00100,
		ST_DATA  = 5'b01000,
		ST_STAMP = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CountW-1:0]  count_q;
	logic [31:0]        stamp_q;
	logic [31:0]        new_stamp_q;
	logic               stamp_pend_q;
	logic [3:0][7:0]    bytes_q;
	logic [2:0]         nb_q;
	logic [AddrW-1:0]   widx_q;
	logic               valid_q;
	logic [31:0]        word_q;
	logic               last_q;

	logic               out_free;
	logic               emit;
	logic               full;
	logic [2:0]         nb_clamp;
	logic [21:0]        len_v;
	logic [AddrW-1:0]   last_widx;
	logic               last_word;
	buf_ctl_t           buf_ctl;
	logic [AddrW-1:0]   wr_addr;
	logic [AddrW-1:0]   rd_addr;
	logic [3:0][7:0]    rd_data;
	logic [3:0][7:0]    data_word;

	assign item_stall  = (state_q != ST_IDLE);
	assign frame_valid = valid_q;
	assign word        = word_q;
	assign last        = last_q;

	assign out_free  = !valid_q || !frame_stall;
	assign emit      = out_free && (state_q inside {ST_HDR, ST_DATA, ST_STAMP});
	assign full      = (count_q == CountW'(MaxBlockBytes));
	assign nb_clamp  = (nbytes > 3'd4) ? 3'd4 : nbytes;
	assign len_v     = value[21:0];
	assign last_widx = AddrW'((count_q - CountW'(1)) >> 2);
	assign last_word = (widx_q == last_widx);

	always_comb begin
		buf_ctl.wr_en = (state_q == ST_BYTES) && !full;
		buf_ctl.lane  = count_q[1:0];
		buf_ctl.rd_en = out_free && ((state_q == ST_HDR) || ((state_q == ST_DATA) && !last_word));
		wr_addr       = AddrW'(count_q >> 2);
		rd_addr       = (state_q == ST_HDR) ? '0 : AddrW'(widx_q + 1'b1);
	end

	// zero the bytes past the count in the final word
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (!last_word || (count_q[1:0] == 2'd0) || (2'(l) < count_q[1:0])) begin
				data_word[3 - l] = rd_data[3 - l];
			end else begin
				data_word[3 - l] = 8'h00;
			end
		end
	end

	tbf_buffer #(
		.MaxBlockBytes(MaxBlockBytes)
	) u_buffer (
		.clk     (clk),
		.ctl     (buf_ctl),
		.wr_addr (wr_addr),
		.wr_data (bytes_q[3]),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			stamp_q      <= '0;
			stamp_pend_q <= 1'b0;
			nb_q         <= '0;
			valid_q      <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!frame_stall) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (cmd_t'(cmd))
							CMD_WRITE: begin
								bytes_q <= value << {3'd4 - nb_clamp, 3'b000};
								nb_q    <= nb_clamp;
								if (nb_clamp != 3'd0) begin
									state_q <= ST_BYTES;
								end
							end
							CMD_LENGTH: begin
								bytes_q <= {len_v > LEN_ONE_MAX, len_v[6:0],
									len_v > LEN_TWO_MAX, len_v[13:7], len_v[21:14], 8'h00};
								if (len_v > LEN_TWO_MAX) begin
									nb_q <= 3'd3;
								end else if (len_v > LEN_ONE_MAX) begin
									nb_q <= 3'd2;
								end else begin
									nb_q <= 3'd1;
								end
								state_q <= ST_BYTES;
							end
							CMD_STAMP: begin
								if (stamp_flush && (value > stamp_q) && (count_q != '0)) begin
									new_stamp_q  <= value;
									stamp_pend_q <= 1'b1;
									nb_q         <= '0;
									state_q      <= ST_HDR;
								end else begin
									stamp_q <= value;
								end
							end
							default: begin
								if (count_q != '0) begin
									nb_q    <= '0;
									state_q <= ST_HDR;
								end
							end
						endcase
					end
				end
				ST_BYTES: begin
					if (full) begin
						state_q <= ST_HDR;
					end else begin
						count_q <= count_q + 1'b1;
						bytes_q <= bytes_q << 8;
						nb_q    <= nb_q - 3'd1;
						if (nb_q == 3'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_HDR: begin
					if (out_free) begin
						word_q  <= 32'(count_q);
						last_q  <= 1'b0;
						widx_q  <= '0;
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (out_free) begin
						word_q  <= data_word;
						last_q  <= 1'b0;
						if (last_word) begin
							state_q <= ST_STAMP;
						end else begin
							widx_q <= AddrW'(widx_q + 1'b1);
						end
					end
				end
				ST_STAMP: begin
					if (out_free) begin
						word_q  <= stamp_q;
						last_q  <= 1'b1;
						count_q <= '0;
						if (stamp_pend_q) begin
							stamp_q      <= new_stamp_q;
							stamp_pend_q <= 1'b0;
						end
						state_q <= (nb_q != 3'd0) ? ST_BYTES : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TBF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountW'(MaxBlockBytes))
	`TBF_ASSERT_NOW(a_no_write_full, buf_ctl.wr_en, !full && (state_q == ST_BYTES))
	`TBF_ASSERT_NEXT(a_stamp_word, (state_q == ST_STAMP) && out_free,
		frame_valid && last && (word == $past(stamp_q)))
	`TBF_ASSERT_NEXT(a_flush_empties, (state_q == ST_STAMP) && out_free, count_q == '0)
	`TBF_ASSERT_NOW(a_hdr_nonempty, state_q == ST_HDR, count_q != '0)

endmodule
